// File: src/rnc_pkg.sv
// Package for the radius neighbour classifier: item types, constants and shared structs.
`timescale 1ns / 1ps

package rnc_pkg;

    localparam int ENTRIES_DEF      = 256;
    localparam int FEATURE_BITS_DEF = 16;

    localparam int FIELD_W  = 16;
    localparam int INDEX_W  = 8;
    localparam int LABEL_W  = 8;
    localparam int RADIUS_W = 16;
    localparam int COUNT_W  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd4915;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 9'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT   = 2'd1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] entry_index;
        logic [FIELD_W-1:0] hue;
        logic [FIELD_W-1:0] saturation;
        logic [FIELD_W-1:0] brightness;
        logic [FIELD_W-1:0] size_x;
        logic [FIELD_W-1:0] size_y;
        logic [FIELD_W-1:0] size_z;
        logic [LABEL_W-1:0] label_in;
    } t_item_in;

    typedef struct packed {
        logic [LABEL_W-1:0] label_out;
        logic               found;
    } t_item_out;

    typedef struct packed {
        logic valid;
        logic clear;
    } t_scan_ctl;

    typedef struct packed {
        logic               idle;
        logic               found;
        logic [LABEL_W-1:0] label;
    } t_scan_stat;

endpackage

// File: src/rnc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module rnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/rnc_datapath.sv
// Scan pipeline: distance terms, radius test and best-entry selection.
`timescale 1ns / 1ps

module rnc_datapath
    import rnc_pkg::*;
#(
    parameter int FEATURE_BITS = FEATURE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_scan_ctl                       i_ctl,
    input  t_item_in                        i_item,
    input  logic [RADIUS_W-1:0]             i_radius,
    input  logic [6*FEATURE_BITS+LABEL_W-1:0] i_rd_data,
    output t_scan_stat                      o_stat
);

    localparam int FB = FEATURE_BITS;
    localparam int SQ_W = 2 * FB;
    localparam int D2_W = 2 * FB + 2;
    localparam int SS_W = FB + 2;
    localparam int R2_W = 2 * RADIUS_W;
    localparam int CMP_W = (D2_W > R2_W) ? D2_W : R2_W;

    function automatic logic [FB-1:0] abs_diff(input logic [FB-1:0] a, input logic [FB-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    logic [FB-1:0]      r_qc [3];
    logic [FB-1:0]      r_qs [3];
    logic [R2_W-1:0]    r_r2;

    logic               r_v1, r_v2, r_v3, r_v4;
    logic [FB-1:0]      r_cd [3];
    logic [FB-1:0]      r_sd [3];
    logic [LABEL_W-1:0] r_lab2, r_lab3, r_lab4;
    logic [SQ_W-1:0]    r_sq [3];
    logic [SS_W-1:0]    r_ss3, r_ss4;
    logic [D2_W-1:0]    r_d2;
    logic               r_in;

    logic               r_have;
    logic [SS_W-1:0]    r_best_ss;
    logic [D2_W-1:0]    r_best_d2;
    logic [LABEL_W-1:0] r_best_lab;

    logic [FB-1:0]      e_c [3];
    logic [FB-1:0]      e_s [3];
    logic [LABEL_W-1:0] e_lab;
    logic [D2_W-1:0]    n_d2;
    logic               n_better;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e_c[k] = i_rd_data[k*FB +: FB];
            e_s[k] = i_rd_data[(k+3)*FB +: FB];
        end
        e_lab = i_rd_data[6*FB +: LABEL_W];
        n_d2 = D2_W'(r_sq[0]) + D2_W'(r_sq[1]) + D2_W'(r_sq[2]);
        n_better = !r_have || (r_ss4 < r_best_ss) ||
                   ((r_ss4 == r_best_ss) && (r_d2 < r_best_d2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (i_ctl.clear) begin
                r_have <= 1'b0;
            end else if (r_v4 && r_in && n_better) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_qc[0] <= FB'(i_item.hue);
            r_qc[1] <= FB'(i_item.saturation);
            r_qc[2] <= FB'(i_item.brightness);
            r_qs[0] <= FB'(i_item.size_x);
            r_qs[1] <= FB'(i_item.size_y);
            r_qs[2] <= FB'(i_item.size_z);
            r_r2    <= i_radius * i_radius;
        end
        for (int k = 0; k < 3; k++) begin
            r_cd[k] <= abs_diff(r_qc[k], e_c[k]);
            r_sd[k] <= abs_diff(r_qs[k], e_s[k]);
            r_sq[k] <= r_cd[k] * r_cd[k];
        end
        r_lab2 <= e_lab;
        r_ss3  <= SS_W'(r_sd[0]) + SS_W'(r_sd[1]) + SS_W'(r_sd[2]);
        r_lab3 <= r_lab2;
        r_d2   <= n_d2;
        r_in   <= CMP_W'(n_d2) <= CMP_W'(r_r2);
        r_ss4  <= r_ss3;
        r_lab4 <= r_lab3;
        if (r_v4 && r_in && n_better) begin
            r_best_ss  <= r_ss4;
            r_best_d2  <= r_d2;
            r_best_lab <= r_lab4;
        end
    end

    assign o_stat.idle  = !(i_ctl.valid || r_v1 || r_v2 || r_v3 || r_v4);
    assign o_stat.found = r_have;
    assign o_stat.label = r_have ? r_best_lab : '0;

endmodule

// File: src/radius_neighbor_classifier.sv
// Top level of the radius neighbour classifier: control, configuration and table.
//
//   channel   signals                          handshake
//   input     i_item (t_item_in)               taken when i_start && !o_busy
//   result    o_result (t_item_out)            shown for one cycle with o_strobe
//   config    i_cfg_we, i_cfg_idx, i_cfg_data  written when i_cfg_we is high
//
// A write item stores its entry in the cycle it is taken and gives no result.
// A query reads the table memory one entry a cycle, up to min(entry_count, ENTRIES)
// entries, followed by the distance and selection pipeline.
// Reset is synchronous and active low; the table holds nothing valid until written.
// The receiver cannot stall, so the result is shown once and the block is free again.
`timescale 1ns / 1ps

module radius_neighbor_classifier
    import rnc_pkg::*;
#(
    parameter int ENTRIES      = ENTRIES_DEF,
    parameter int FEATURE_BITS = FEATURE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_item_in              i_item,
    output logic                  o_strobe,
    output t_item_out             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FB     = FEATURE_BITS;
    localparam int AW     = $clog2(ENTRIES);
    localparam int CW     = $clog2(ENTRIES + 1);
    localparam int WORD_W = 6 * FB + LABEL_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_limit;
    logic                r_strobe;
    t_item_out           r_result;
    logic [RADIUS_W-1:0] r_radius;
    logic [COUNT_W-1:0]  r_entry_count;

    logic                accept;
    logic [CW-1:0]       n_limit;
    logic                wr_en;
    logic [WORD_W-1:0]   wr_data;
    t_scan_ctl           ctl;
    t_scan_stat          stat;
    logic [WORD_W-1:0]   rd_data;

    assign accept  = i_start && (r_state == S_IDLE);
    assign n_limit = (32'(r_entry_count) > ENTRIES) ? CW'(ENTRIES) : CW'(r_entry_count);
    assign wr_en   = accept && (i_item.kind == KIND_WRITE) &&
                     (32'(i_item.entry_index) < ENTRIES);
    assign wr_data = {i_item.label_in, FB'(i_item.size_z), FB'(i_item.size_y),
                      FB'(i_item.size_x), FB'(i_item.brightness),
                      FB'(i_item.saturation), FB'(i_item.hue)};

    assign ctl.valid = (r_state == S_SCAN) && (r_cnt != r_limit);
    assign ctl.clear = accept && (i_item.kind == KIND_QUERY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= RADIUS_RESET;
            r_entry_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEARCH_RADIUS: r_radius      <= RADIUS_W'(i_cfg_data);
                CFG_ENTRY_COUNT:   r_entry_count <= COUNT_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_limit  <= '0;
            r_strobe <= 1'b0;
            r_result <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (ctl.clear) begin
                        r_cnt   <= '0;
                        r_limit <= n_limit;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (ctl.valid) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (stat.idle) begin
                        r_strobe           <= 1'b1;
                        r_result.found     <= stat.found;
                        r_result.label_out <= stat.label;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    rnc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_item.entry_index)),
        .i_wdata (wr_data),
        .i_re    (ctl.valid),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (rd_data)
    );

    rnc_datapath #(
        .FEATURE_BITS (FEATURE_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_item    (i_item),
        .i_radius  (r_radius),
        .i_rd_data (rd_data),
        .o_stat    (stat)
    );

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
